// ===== sv/btn_rpt_pkg.sv =====
// shared constants, types and helpers for the button auto-repeat block
`default_nettype none

package btn_rpt_pkg;

  // accumulator width and register width
  localparam int TIME_BITS = 16;
  localparam int CFG_BITS  = 16;
  // serial datapath width: wide enough for both the accumulator and the registers
  localparam int CALC_BITS = (TIME_BITS > CFG_BITS) ? TIME_BITS : CFG_BITS;
  localparam int CNT_BITS  = $clog2(CALC_BITS + 1);

  localparam int ACT_BITS     = 3;
  localparam int CFG_IDX_BITS = 2;

  typedef logic [TIME_BITS-1:0]    time_t;
  typedef logic [CFG_BITS-1:0]     cfg_word_t;
  typedef logic [CALC_BITS-1:0]    calc_t;
  typedef logic [CNT_BITS-1:0]     cnt_t;
  typedef logic [ACT_BITS-1:0]     action_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;

  // event codes
  localparam action_t ACT_PRESS       = 3'd0;
  localparam action_t ACT_RELEASE     = 3'd1;
  localparam action_t ACT_RELEASE_OUT = 3'd2;
  localparam action_t ACT_CLICK       = 3'd3;
  localparam action_t ACT_TICK        = 3'd4;

  // register indexes
  localparam cfg_idx_t REG_DELAY    = 2'd0;
  localparam cfg_idx_t REG_INTERVAL = 2'd1;
  localparam cfg_idx_t REG_CALLBACK = 2'd2;

  localparam time_t ACC_MAX = '1;

  // status of the serial add/subtract unit
  typedef struct packed {
    logic done;
    logic below;
  } alu_stat_t;

  // fit a register-width value into the accumulator width
  function automatic time_t fit_time(input cfg_word_t v);
    calc_t w;
    w = calc_t'(v);
    return w[TIME_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/btn_rpt_if.sv =====
// handshake channels of the button auto-repeat block
`default_nettype none

interface btn_rpt_evt_if;
  logic                     valid;
  logic                     ready;
  btn_rpt_pkg::action_t     action;
  btn_rpt_pkg::cfg_word_t   tick_ms;
  logic                     pointer_inside;

  modport source (output valid, output action, output tick_ms,
                  output pointer_inside, input ready);
  modport sink (input valid, input action, input tick_ms,
                input pointer_inside, output ready);
endinterface

interface btn_rpt_res_if;
  logic valid;
  logic ready;
  logic click_fire;
  logic repaint;

  modport source (output valid, output click_fire, output repaint, input ready);
  modport sink (input valid, input click_fire, input repaint, output ready);
endinterface

interface btn_rpt_cfg_if;
  logic                   valid;
  logic                   ready;
  btn_rpt_pkg::cfg_idx_t  index;
  btn_rpt_pkg::cfg_word_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/btn_rpt_alu.sv =====
// bit-serial saturating add followed by bit-serial subtract of the threshold
`default_nettype none

module btn_rpt_alu (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  btn_rpt_pkg::time_t     acc,
  input  btn_rpt_pkg::cfg_word_t ms,
  input  btn_rpt_pkg::cfg_word_t thr,
  output btn_rpt_pkg::alu_stat_t stat,
  output btn_rpt_pkg::time_t     total,
  output btn_rpt_pkg::calc_t     diff
);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_ADD  = 2'd1;
  localparam logic [1:0] P_LOAD = 2'd2;
  localparam logic [1:0] P_SUB  = 2'd3;

  localparam int CB = btn_rpt_pkg::CALC_BITS;
  localparam int TB = btn_rpt_pkg::TIME_BITS;
  localparam int NB = btn_rpt_pkg::CNT_BITS;

  logic [1:0]              phase;
  btn_rpt_pkg::cnt_t       cnt;
  btn_rpt_pkg::calc_t      a_sr;
  btn_rpt_pkg::calc_t      b_sr;
  btn_rpt_pkg::calc_t      r_sr;
  logic                    cy;
  logic                    ovf;
  logic                    last;
  logic                    a0;
  logic                    b0;
  logic                    s_add;
  logic                    c_add;
  logic                    s_sub;
  logic                    c_sub;
  btn_rpt_pkg::time_t      sat_total;

  assign a0    = a_sr[0];
  assign b0    = b_sr[0];
  assign s_add = a0 ^ b0 ^ cy;
  assign c_add = (a0 & b0) | (cy & (a0 ^ b0));
  assign s_sub = a0 ^ b0 ^ cy;
  assign c_sub = (~a0 & b0) | (~(a0 ^ b0) & cy);
  assign last  = (cnt == NB'(CB - 1));

  // carry out or any bit above the accumulator width means saturate
  assign sat_total = (cy || ovf) ? btn_rpt_pkg::ACC_MAX : r_sr[TB-1:0];

  assign diff = r_sr;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= P_IDLE;
      stat.done  <= 1'b0;
      stat.below <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            a_sr  <= CB'(acc);
            b_sr  <= CB'(ms);
            cy    <= 1'b0;
            ovf   <= 1'b0;
            cnt   <= '0;
            phase <= P_ADD;
          end
        end
        P_ADD: begin
          a_sr <= {1'b0, a_sr[CB-1:1]};
          b_sr <= {1'b0, b_sr[CB-1:1]};
          r_sr <= {s_add, r_sr[CB-1:1]};
          cy   <= c_add;
          if (s_add && (cnt >= NB'(TB))) begin
            ovf <= 1'b1;
          end
          cnt <= cnt + 1'b1;
          if (last) begin
            phase <= P_LOAD;
          end
        end
        P_LOAD: begin
          total <= sat_total;
          a_sr  <= CB'(sat_total);
          b_sr  <= CB'(thr);
          cy    <= 1'b0;
          cnt   <= '0;
          phase <= P_SUB;
        end
        P_SUB: begin
          a_sr <= {1'b0, a_sr[CB-1:1]};
          b_sr <= {1'b0, b_sr[CB-1:1]};
          r_sr <= {s_sub, r_sr[CB-1:1]};
          cy   <= c_sub;
          cnt  <= cnt + 1'b1;
          if (last) begin
            stat.done  <= 1'b1;
            stat.below <= c_sub;
            phase      <= P_IDLE;
          end
        end
        default: begin
          phase <= P_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/btn_rpt_rem.sv =====
// restoring remainder unit, one numerator bit per cycle, msb first
`default_nettype none

module btn_rpt_rem (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  btn_rpt_pkg::calc_t     num,
  input  btn_rpt_pkg::cfg_word_t den,
  output logic                   done,
  output btn_rpt_pkg::cfg_word_t rem
);

  localparam int CB = btn_rpt_pkg::CALC_BITS;
  localparam int FB = btn_rpt_pkg::CFG_BITS;
  localparam int NB = btn_rpt_pkg::CNT_BITS;

  logic                   busy;
  btn_rpt_pkg::cnt_t      cnt;
  btn_rpt_pkg::calc_t     num_sr;
  logic [FB:0]            trial;
  logic [FB:0]            trial_sub;
  logic                   ge;
  btn_rpt_pkg::cfg_word_t rem_next;

  assign trial     = {rem, num_sr[CB-1]};
  assign trial_sub = trial - {1'b0, den};
  assign ge        = (trial >= {1'b0, den});
  assign rem_next  = ge ? trial_sub[FB-1:0] : trial[FB-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        num_sr <= {num_sr[CB-2:0], 1'b0};
        rem    <= rem_next;
        cnt    <= cnt + 1'b1;
        if (cnt == NB'(CB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        num_sr <= num;
        rem    <= '0;
        cnt    <= '0;
        busy   <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/button_auto_repeat.sv =====
// top level of the button auto-repeat block: event sequencer, registers, result stage
//
// channels
//   evt : one item per button event (action, tick_ms, pointer_inside)
//   res : exactly one item per event (click_fire, repaint)
//   cfg : register writes, index 0 first-repeat delay, 1 repeat period,
//         2 callback enable; always ready, other indexes are ignored
// throughput and sequence
//   one event is worked on at a time; evt.ready is high only while the
//   sequencer is idle
//   press, release, click and ticks that do no timing: from idle straight to
//   the done state, which loads the result stage once it is free
//   timing ticks: serial add, load, serial subtract, then the done state;
//   a tick that reaches its threshold also runs the serial remainder
//   before the done state
// reset
//   synchronous, clears registers, timing state and the result stage
// receiver stall
//   the result stage holds its item; the next event is still accepted and
//   worked on, and waits for the result stage to empty before finishing
//   cfg writes are expected only while no event is in flight
`default_nettype none

module button_auto_repeat (
  input  logic                 clk,
  input  logic                 rst,
  btn_rpt_evt_if.sink          evt,
  btn_rpt_res_if.source        res,
  btn_rpt_cfg_if.sink          cfg
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ALU  = 2'd1;
  localparam logic [1:0] S_REM  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  // configuration registers
  btn_rpt_pkg::cfg_word_t delay_ms;
  btn_rpt_pkg::cfg_word_t period_ms;
  logic                   callback_enabled;

  // timing state
  btn_rpt_pkg::time_t time_accumulated;
  logic               repeating;
  logic               repeat_happened;
  logic               held_down;

  logic [1:0] state;
  logic       res_fire;
  logic       res_paint;

  // result stage
  logic out_valid;
  logic out_click;
  logic out_paint;
  logic out_free;

  logic                   evt_accept;
  logic                   repeat_off;
  logic                   alu_start;
  logic                   rem_start;
  btn_rpt_pkg::cfg_word_t thr;
  btn_rpt_pkg::alu_stat_t alu_stat;
  btn_rpt_pkg::time_t     alu_total;
  btn_rpt_pkg::calc_t     alu_diff;
  logic                   rem_done;
  btn_rpt_pkg::cfg_word_t rem_val;

  assign evt.ready      = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign res.valid      = out_valid;
  assign res.click_fire = out_click;
  assign res.repaint    = out_paint;

  assign evt_accept = evt.valid && evt.ready;
  assign out_free   = !out_valid || res.ready;
  assign repeat_off = (delay_ms == '0) || (period_ms == '0);

  // first threshold is the delay, later ones the period
  assign thr = repeating ? period_ms : delay_ms;

  // timing work only for a tick with repeat on and the pointer over the button
  assign alu_start = evt_accept && (evt.action == btn_rpt_pkg::ACT_TICK) &&
                     !repeat_off && evt.pointer_inside;
  assign rem_start = (state == S_ALU) && alu_stat.done && !alu_stat.below;

  btn_rpt_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (alu_start),
    .acc   (time_accumulated),
    .ms    (evt.tick_ms),
    .thr   (thr),
    .stat  (alu_stat),
    .total (alu_total),
    .diff  (alu_diff)
  );

  // remainder of the overshoot modulo the period
  btn_rpt_rem u_rem (
    .clk   (clk),
    .rst   (rst),
    .start (rem_start),
    .num   (alu_diff),
    .den   (period_ms),
    .done  (rem_done),
    .rem   (rem_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ms         <= '0;
      period_ms        <= '0;
      callback_enabled <= 1'b0;
      time_accumulated <= '0;
      repeating        <= 1'b0;
      repeat_happened  <= 1'b0;
      held_down        <= 1'b0;
      state            <= S_IDLE;
      res_fire         <= 1'b0;
      res_paint        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end

      // register writes; a timing register write restarts the timing
      if (cfg.valid && cfg.ready) begin
        unique case (cfg.index)
          btn_rpt_pkg::REG_DELAY: begin
            delay_ms         <= cfg.data;
            time_accumulated <= '0;
            repeating        <= 1'b0;
            if (!held_down) begin
              repeat_happened <= 1'b0;
            end
          end
          btn_rpt_pkg::REG_INTERVAL: begin
            period_ms        <= cfg.data;
            time_accumulated <= '0;
            repeating        <= 1'b0;
            if (!held_down) begin
              repeat_happened <= 1'b0;
            end
          end
          btn_rpt_pkg::REG_CALLBACK: begin
            callback_enabled <= cfg.data[0];
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (evt_accept) begin
            res_fire  <= 1'b0;
            res_paint <= 1'b0;
            state     <= S_DONE;
            unique case (evt.action)
              btn_rpt_pkg::ACT_PRESS: begin
                time_accumulated <= '0;
                repeating        <= 1'b0;
                repeat_happened  <= 1'b0;
                held_down        <= 1'b1;
                res_paint        <= 1'b1;
              end
              btn_rpt_pkg::ACT_RELEASE: begin
                // repeat_happened kept so the following click is suppressed
                time_accumulated <= '0;
                repeating        <= 1'b0;
                held_down        <= 1'b0;
                res_paint        <= 1'b1;
              end
              btn_rpt_pkg::ACT_RELEASE_OUT: begin
                time_accumulated <= '0;
                repeating        <= 1'b0;
                repeat_happened  <= 1'b0;
                held_down        <= 1'b0;
                res_paint        <= 1'b1;
              end
              btn_rpt_pkg::ACT_CLICK: begin
                res_fire        <= !repeat_happened && callback_enabled;
                repeat_happened <= 1'b0;
              end
              btn_rpt_pkg::ACT_TICK: begin
                if (!repeat_off) begin
                  if (evt.pointer_inside) begin
                    state <= S_ALU;
                  end else begin
                    // dragged off the button
                    time_accumulated <= '0;
                    repeating        <= 1'b0;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ALU: begin
          if (alu_stat.done) begin
            if (alu_stat.below) begin
              time_accumulated <= alu_total;
              state            <= S_DONE;
            end else begin
              state <= S_REM;
            end
          end
        end
        S_REM: begin
          if (rem_done) begin
            time_accumulated <= btn_rpt_pkg::fit_time(rem_val);
            repeating        <= 1'b1;
            repeat_happened  <= 1'b1;
            res_fire         <= callback_enabled;
            state            <= S_DONE;
          end
        end
        S_DONE: begin
          // wait for the result stage to empty
          if (out_free) begin
            out_valid <= 1'b1;
            out_click <= res_fire;
            out_paint <= res_paint;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/btn_rpt_checker.sv =====
// port-level checks of the button auto-repeat block and their binding
`default_nettype none

module btn_rpt_checker (
  input logic clk,
  input logic rst,
  input logic evt_valid,
  input logic evt_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_click_fire,
  input logic res_repaint
);

  // a stalled result item keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_click_fire) &&
    $stable(res_repaint))
    else $error("result item changed while stalled");

  // result stage empties on reset
  a_res_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // one event in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> !evt_ready)
    else $error("event accepted while another is in flight");

  // a repaint event never fires a click
  a_paint_no_fire: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_click_fire && res_repaint))
    else $error("click and repaint on the same item");

endmodule

bind button_auto_repeat btn_rpt_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .res_valid      (res.valid),
  .res_ready      (res.ready),
  .res_click_fire (res.click_fire),
  .res_repaint    (res.repaint)
);

`default_nettype wire
